/* design/dqp_pkg.sv */
// ----------------------------------------------------------------------------
// dqp_pkg
// Shared types and constants for the dotted-quad address parser.
// ----------------------------------------------------------------------------
`default_nettype none

package dqp_pkg;

   localparam int unsigned QueueDepth = 4;

   localparam logic [63:0] NilReset  = 64'h8000_0000_0000_0000;
   localparam logic [63:0] TagPrefix = 64'h0000_0020_0000_0000;

   localparam logic [7:0] ChTerm  = 8'h00;
   localparam logic [7:0] ChDot   = 8'h2E;
   localparam logic [7:0] ChZero  = 8'h30;
   localparam logic [7:0] ChNine  = 8'h39;

   localparam logic [1:0] CLS_DIGIT = 2'd0;
   localparam logic [1:0] CLS_DOT   = 2'd1;
   localparam logic [1:0] CLS_TERM  = 2'd2;
   localparam logic [1:0] CLS_OTHER = 2'd3;

   localparam logic [1:0] LAST_OCTET = 2'd3;

   typedef struct packed {
      logic [1:0] cls;
      logic [3:0] digit;
   } dqp_item_type;

endpackage

`default_nettype wire

/* design/ipv4_dotted_quad_parser.sv */
// ----------------------------------------------------------------------------
// ipv4_dotted_quad_parser
// Streaming parser of dotted-decimal IPv4 address text.
// ----------------------------------------------------------------------------
// Feed one character per item on req_ch; a zero byte ends the field. Each
// terminator gives one item on the rsp_ channel: rsp_ok, rsp_address (first
// octet in bits 7..0, zero on failure) and rsp_tagged_word (prefix 0x20 in
// bits 39..32 OR address, or the nil word on failure). Other characters give
// no result item.
// Throughput: one character per cycle, sustained while req_stall stays low;
// the parse engine applies each item to the octet state.
// A terminator reaches the result outputs through the input register, the
// queue and the result register, in that order.
// When rsp_stall and rsp_valid are both high the result register holds; characters keep flowing
// until a terminator reaches the head of the queue, then the queue fills and
// req_stall rises.
// csr_data sets the nil word; csr_ready is always high; write only while idle.
// Reset clears the parse state, the queue and the result valid flag, and sets
// the nil word to 0x8000000000000000.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_dotted_quad_parser
   import dqp_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic [7:0]    req_ch,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic               rsp_ok,
   output logic [31:0]        rsp_address,
   output logic [63:0]        rsp_tagged_word,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [63:0]   csr_data
);

   logic         push_valid;
   dqp_item_type push_item;
   logic         push_ready;
   logic         pop_valid;
   dqp_item_type pop_item;
   logic         pop_ready;

   assign csr_ready = 1'b1;

   dqp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   dqp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready)
   );

   dqp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_item        (pop_item),
      .pop_ready       (pop_ready),
      .csr_write       (csr_valid && csr_ready),
      .csr_data        (csr_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_ok          (rsp_ok),
      .rsp_address     (rsp_address),
      .rsp_tagged_word (rsp_tagged_word)
   );

endmodule

`default_nettype wire

/* design/dqp_front.sv */
// ----------------------------------------------------------------------------
// dqp_front
// Input stage: accepts one character per cycle while req_stall is low,
// classifies it and hands the classified item to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dqp_front
   import dqp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic [7:0]   req_ch,
   output logic              push_valid,
   output dqp_item_type      push_item,
   input  wire logic         push_ready
);

   logic         front_valid_ff;
   logic         front_valid_in;
   dqp_item_type front_item_ff;
   dqp_item_type front_item_in;
   logic         accept;

   always_comb begin
      front_item_in.digit = req_ch[3:0];
      if (req_ch == ChTerm) begin
         front_item_in.cls = CLS_TERM;
      end else if (req_ch == ChDot) begin
         front_item_in.cls = CLS_DOT;
      end else if (req_ch >= ChZero && req_ch <= ChNine) begin
         front_item_in.cls = CLS_DIGIT;
      end else begin
         front_item_in.cls = CLS_OTHER;
      end
   end

   assign req_stall  = front_valid_ff && !push_ready;
   assign accept     = req_valid && !req_stall;
   assign push_valid = front_valid_ff;
   assign push_item  = front_item_ff;

   always_comb begin
      front_valid_in = front_valid_ff;
      if (accept) begin
         front_valid_in = 1'b1;
      end else if (push_ready) begin
         front_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         front_item_ff <= front_item_in;
      end
   end

endmodule

`default_nettype wire

/* design/dqp_queue.sv */
// ----------------------------------------------------------------------------
// dqp_queue
// Short first-in first-out queue of classified items between the input stage
// and the parse engine.
// ----------------------------------------------------------------------------
`default_nettype none

module dqp_queue
   import dqp_pkg::*;
#(
   parameter int unsigned DEPTH = QueueDepth
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push_valid,
   input  wire dqp_item_type push_item,
   output logic              push_ready,
   output logic              pop_valid,
   output dqp_item_type      pop_item,
   input  wire logic         pop_ready
);

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);

   dqp_item_type          slot_ff [DEPTH];
   logic [PtrW-1:0]       wr_ptr_ff;
   logic [PtrW-1:0]       wr_ptr_in;
   logic [PtrW-1:0]       rd_ptr_ff;
   logic [PtrW-1:0]       rd_ptr_in;
   logic [CntW-1:0]       count_ff;
   logic [CntW-1:0]       count_in;
   logic                  push;
   logic                  pop;

   assign push_ready = (count_ff != CntW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(DEPTH))
      else $error("queue count above depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + CntW'(1)))
      else $error("queue count did not advance on push");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with unequal pointers");

endmodule

`default_nettype wire

/* design/dqp_back.sv */
// ----------------------------------------------------------------------------
// dqp_back
// Parse engine: applies one classified item per cycle (unless a result stalls)
// to the octet state and registers the result of each terminated field.
// ----------------------------------------------------------------------------
`default_nettype none

module dqp_back
   import dqp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          pop_valid,
   input  wire dqp_item_type  pop_item,
   output logic               pop_ready,
   input  wire logic          csr_write,
   input  wire logic [63:0]   csr_data,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic               rsp_ok,
   output logic [31:0]        rsp_address,
   output logic [63:0]        rsp_tagged_word
);

   logic [63:0] nil_word_ff;
   logic [1:0]  octet_index_ff;
   logic [1:0]  octet_index_in;
   logic [7:0]  octet_value_ff;
   logic [7:0]  octet_value_in;
   logic        octet_has_digit_ff;
   logic        octet_has_digit_in;
   logic        octet_over_range_ff;
   logic        octet_over_range_in;
   logic        parse_failed_ff;
   logic        parse_failed_in;
   logic [23:0] packed_octets_ff;
   logic [23:0] packed_octets_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic        rsp_ok_ff;
   logic [31:0] rsp_address_ff;
   logic [63:0] rsp_tagged_word_ff;
   logic        is_term;
   logic        pop;
   logic        good;
   logic [31:0] good_address;
   logic [11:0] digit_sum;

   assign is_term   = (pop_item.cls == CLS_TERM);
   assign pop_ready = !is_term || !rsp_valid_ff || !rsp_stall;
   assign pop       = pop_valid && pop_ready;

   assign digit_sum = {1'b0, octet_value_ff, 3'b000} + {3'b000, octet_value_ff, 1'b0}
                    + {8'h00, pop_item.digit};

   assign good = !parse_failed_ff && (octet_index_ff == LAST_OCTET)
              && octet_has_digit_ff && !octet_over_range_ff;
   assign good_address = good ? {octet_value_ff, packed_octets_ff} : 32'h0;

   always_comb begin
      octet_index_in      = octet_index_ff;
      octet_value_in      = octet_value_ff;
      octet_has_digit_in  = octet_has_digit_ff;
      octet_over_range_in = octet_over_range_ff;
      parse_failed_in     = parse_failed_ff;
      packed_octets_in    = packed_octets_ff;
      if (pop) begin
         if (is_term) begin
            octet_index_in      = '0;
            octet_value_in      = '0;
            octet_has_digit_in  = 1'b0;
            octet_over_range_in = 1'b0;
            parse_failed_in     = 1'b0;
            packed_octets_in    = '0;
         end else if (!parse_failed_ff) begin
            unique case (pop_item.cls)
               CLS_DIGIT: begin
                  octet_has_digit_in = 1'b1;
                  if (!octet_over_range_ff) begin
                     if (digit_sum > 12'd255) begin
                        octet_over_range_in = 1'b1;
                     end else begin
                        octet_value_in = digit_sum[7:0];
                     end
                  end
               end
               CLS_DOT: begin
                  if (octet_index_ff != LAST_OCTET && octet_has_digit_ff
                      && !octet_over_range_ff) begin
                     case (octet_index_ff)
                        2'd0:    packed_octets_in[7:0]   = octet_value_ff;
                        2'd1:    packed_octets_in[15:8]  = octet_value_ff;
                        2'd2:    packed_octets_in[23:16] = octet_value_ff;
                        default: packed_octets_in        = packed_octets_ff;
                     endcase
                     octet_index_in     = octet_index_ff + 2'd1;
                     octet_value_in     = '0;
                     octet_has_digit_in = 1'b0;
                  end else begin
                     parse_failed_in = 1'b1;
                  end
               end
               default: begin
                  parse_failed_in = 1'b1;
               end
            endcase
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop && is_term) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nil_word_ff         <= NilReset;
         octet_index_ff      <= '0;
         octet_value_ff      <= '0;
         octet_has_digit_ff  <= 1'b0;
         octet_over_range_ff <= 1'b0;
         parse_failed_ff     <= 1'b0;
         packed_octets_ff    <= '0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         if (csr_write) begin
            nil_word_ff <= csr_data;
         end
         octet_index_ff      <= octet_index_in;
         octet_value_ff      <= octet_value_in;
         octet_has_digit_ff  <= octet_has_digit_in;
         octet_over_range_ff <= octet_over_range_in;
         parse_failed_ff     <= parse_failed_in;
         packed_octets_ff    <= packed_octets_in;
         rsp_valid_ff        <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && is_term) begin
         rsp_ok_ff          <= good;
         rsp_address_ff     <= good_address;
         rsp_tagged_word_ff <= good ? (TagPrefix | {32'h0, good_address}) : nil_word_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_address     = rsp_address_ff;
   assign rsp_tagged_word = rsp_tagged_word_ff;

   a_ok_tag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ok_ff) |-> (rsp_tagged_word_ff == (TagPrefix | {32'h0, rsp_address_ff})))
      else $error("tagged word does not match address");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ok_ff) |-> (rsp_address_ff == 32'h0))
      else $error("failed parse with nonzero address");

   a_fourth_dot: assert property (@(posedge clock) disable iff (reset)
      (pop && pop_item.cls == CLS_DOT && octet_index_ff == LAST_OCTET) |=> parse_failed_ff)
      else $error("fourth dot did not fail the parse");

   a_term_clear: assert property (@(posedge clock) disable iff (reset)
      (pop && is_term) |=> (octet_index_ff == '0 && !parse_failed_ff && !octet_has_digit_ff))
      else $error("state not cleared after terminator");

   a_over_digit: assert property (@(posedge clock) disable iff (reset)
      octet_over_range_ff |-> octet_has_digit_ff)
      else $error("over-range octet without a digit");

endmodule

`default_nettype wire
